// ===== hw/rtl/pnz_pkg.sv =====
`default_nettype none
package pnz_pkg;

    localparam int PNZ_TABLE_SIZE = 256;
    localparam int PNZ_FRAC_BITS  = 16;
    localparam int PNZ_ENTRY_W    = 8;
    localparam int PNZ_COORD_W    = 32;
    localparam int PNZ_OUT_W      = 17;

    // request kinds carried on s_tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    // table write travelling down the hash pipeline
    typedef struct packed {
        logic                   valid;
        logic [PNZ_ENTRY_W-1:0] index;
        logic [PNZ_ENTRY_W-1:0] value;
    } pnz_wr_t;

endpackage
`default_nettype wire

// ===== hw/rtl/perlin_noise_3d_core.sv =====
// a noise request shows on m_tvalid once it has passed the ev_reg chain and m_tvalid_reg
// throughput: one request per cycle unless m_tready stalls, set by the ten-stage
// pipeline and the replicated permutation copies (two read ports each, seven copies)
// table size must be a power of two; table writes cost a pipeline slot, no result
// reset: aresetn (synchronous, active low) clears the valid bits; table contents stay
`default_nettype none
module perlin_noise_3d_core #(
    parameter int TABLE_SIZE = pnz_pkg::PNZ_TABLE_SIZE,
    parameter int FRAC_BITS  = pnz_pkg::PNZ_FRAC_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // table_index, table_value, coord_x, coord_y, coord_z
    input  wire logic [111:0] s_tdata,
    // req_type
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // noise_value, zero padded
    output logic [23:0]       m_tdata
);
    import pnz_pkg::*;

    localparam int IW    = $clog2(TABLE_SIZE);
    localparam int F     = FRAC_BITS;
    localparam int DEPTH = 10;

    logic                          en;
    logic                          accept;
    logic [DEPTH:1]                ev_reg;
    pnz_wr_t                       wr1_reg;
    logic signed [PNZ_COORD_W-1:0] cin [3];
    logic signed [PNZ_COORD_W-1:0] csh [3];
    logic [1:0][IW-1:0]            cell_reg [3];
    logic [F-1:0]                  fr_reg [3][4];
    logic [F:0]                    fade [3];
    logic [7:0][PNZ_ENTRY_W-1:0]   hash;
    logic [PNZ_OUT_W-1:0]          noise;
    logic                          m_tvalid_reg;
    logic [PNZ_OUT_W-1:0]          m_noise_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    assign cin[0] = $signed(s_tdata[47:16]);
    assign cin[1] = $signed(s_tdata[79:48]);
    assign cin[2] = $signed(s_tdata[111:80]);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            csh[i] = cin[i] >>> F;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_reg        <= '0;
            wr1_reg.valid <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else if (en) begin
            ev_reg        <= {ev_reg[DEPTH-1:1], accept && (s_tuser[0] == REQ_EVAL)};
            wr1_reg.valid <= accept && (s_tuser[0] == REQ_WRITE);
            wr1_reg.index <= s_tdata[7:0];
            wr1_reg.value <= s_tdata[15:8];
            m_tvalid_reg  <= ev_reg[DEPTH];
        end
    end

    // fractions wait out the three hash levels
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                cell_reg[i][0] <= csh[i][IW-1:0];
                cell_reg[i][1] <= csh[i][IW-1:0] + IW'(1);
                fr_reg[i][0]   <= cin[i][F-1:0];
                fr_reg[i][1]   <= fr_reg[i][0];
                fr_reg[i][2]   <= fr_reg[i][1];
                fr_reg[i][3]   <= fr_reg[i][2];
            end
            m_noise_reg <= noise;
        end
    end

    pnz_hash #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_hash (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .wr       (wr1_reg),
        .cell_x   (cell_reg[0]),
        .cell_y   (cell_reg[1]),
        .cell_z   (cell_reg[2]),
        .hash_out (hash)
    );

    for (genvar i = 0; i < 3; i++) begin : g_fade
        pnz_fade #(
            .FRAC_BITS (FRAC_BITS)
        ) u_fade (
            .aclk     (aclk),
            .en       (en),
            .t_in     (fr_reg[i][0]),
            .fade_out (fade[i])
        );
    end

    pnz_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .aclk      (aclk),
        .en        (en),
        .hash_in   (hash),
        .frac_x    (fr_reg[0][3]),
        .frac_y    (fr_reg[1][3]),
        .frac_z    (fr_reg[2][3]),
        .fade_u    (fade[0]),
        .fade_v    (fade[1]),
        .fade_w    (fade[2]),
        .noise_out (noise)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(24 - PNZ_OUT_W)'(0), m_noise_reg};

endmodule
`default_nettype wire

// ===== hw/rtl/pnz_fade.sv =====
`default_nettype none
module pnz_fade #(
    parameter int FRAC_BITS = pnz_pkg::PNZ_FRAC_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic [FRAC_BITS-1:0] t_in,
    output logic      [FRAC_BITS:0]   fade_out
);
    import pnz_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int AW = F + 5;
    localparam int PW = 2 * F + 6;
    localparam int BW = F + 4;

    logic signed [AW-1:0]  a;
    logic signed [PW-1:0]  ta_reg;
    logic [2*F-1:0]        tt_reg;
    logic [F-1:0]          t2_reg;
    logic signed [PW-1:0]  bs;
    logic [F-1:0]          c;
    logic [2*F-1:0]        dt_reg;
    logic [BW-1:0]         b_reg;
    logic [F-1:0]          d;
    logic [2*F+3:0]        db_reg;
    logic [BW-1:0]         r;

    // 6t - 15
    assign a = AW'(AW'(t_in) * AW'(6)) - (AW'(15) << F);

    always_ff @(posedge aclk) begin
        if (en) begin
            ta_reg <= $signed({1'b0, t_in}) * a;
            tt_reg <= t_in * t_in;
            t2_reg <= t_in;
        end
    end

    assign c  = tt_reg[2*F-1:F];
    assign bs = (ta_reg >>> F) + (PW'(10) << F);

    always_ff @(posedge aclk) begin
        if (en) begin
            dt_reg <= c * t2_reg;
            b_reg  <= bs[BW-1:0];
        end
    end

    assign d = dt_reg[2*F-1:F];

    always_ff @(posedge aclk) begin
        if (en) begin
            db_reg <= d * b_reg;
        end
    end

    assign r        = db_reg[2*F+3:F];
    assign fade_out = (r > (BW'(1) << F)) ? ((F+1)'(1) << F) : r[F:0];

endmodule
`default_nettype wire

// ===== hw/rtl/pnz_hash.sv =====
`default_nettype none
module pnz_hash #(
    parameter int TABLE_SIZE = pnz_pkg::PNZ_TABLE_SIZE
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  en,
    input  wire pnz_pkg::pnz_wr_t                      wr,
    input  wire logic [1:0][$clog2(TABLE_SIZE)-1:0]    cell_x,
    input  wire logic [1:0][$clog2(TABLE_SIZE)-1:0]    cell_y,
    input  wire logic [1:0][$clog2(TABLE_SIZE)-1:0]    cell_z,
    output logic      [7:0][pnz_pkg::PNZ_ENTRY_W-1:0]  hash_out
);
    import pnz_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int SW = ((IW > PNZ_ENTRY_W) ? IW : PNZ_ENTRY_W) + 1;

    // one copy per read pair so that every level reads all its corners at once
    logic [PNZ_ENTRY_W-1:0] mem1 [TABLE_SIZE];
    logic [PNZ_ENTRY_W-1:0] mem2 [2][TABLE_SIZE];
    logic [PNZ_ENTRY_W-1:0] mem3 [4][TABLE_SIZE];

    pnz_wr_t                     wr2_reg, wr3_reg;
    logic [1:0][IW-1:0]          y2_reg;
    logic [1:0][IW-1:0]          x2_reg, x3_reg;
    logic [1:0][PNZ_ENTRY_W-1:0] pz_reg;
    logic [3:0][PNZ_ENTRY_W-1:0] py_reg;
    logic [3:0][IW-1:0]          addr2;
    logic [7:0][IW-1:0]          addr3;
    logic [SW-1:0]               sum2 [4];
    logic [SW-1:0]               sum3 [8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr2_reg.valid <= 1'b0;
            wr3_reg.valid <= 1'b0;
        end else if (en) begin
            wr2_reg <= wr;
            wr3_reg <= wr2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y2_reg        <= cell_y;
            x2_reg        <= cell_x;
            x3_reg        <= x2_reg;
        end
    end

    // level one: z corners
    always_ff @(posedge aclk) begin
        if (en) begin
            if (wr.valid) begin
                mem1[IW'(wr.index)] <= wr.value;
            end
            pz_reg[0] <= mem1[cell_z[0]];
            pz_reg[1] <= mem1[cell_z[1]];
        end
    end

    // level two: index j = y + 2z
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            sum2[j]  = SW'(y2_reg[j % 2]) + SW'(pz_reg[j / 2]);
            addr2[j] = sum2[j][IW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                if (wr2_reg.valid) begin
                    mem2[k][IW'(wr2_reg.index)] <= wr2_reg.value;
                end
                py_reg[2*k]   <= mem2[k][addr2[2*k]];
                py_reg[2*k+1] <= mem2[k][addr2[2*k+1]];
            end
        end
    end

    // level three: corner k = x + 2y + 4z
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            sum3[k]  = SW'(x3_reg[k % 2]) + SW'(py_reg[k / 2]);
            addr3[k] = sum3[k][IW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                if (wr3_reg.valid) begin
                    mem3[j][IW'(wr3_reg.index)] <= wr3_reg.value;
                end
                hash_out[2*j]   <= mem3[j][addr3[2*j]];
                hash_out[2*j+1] <= mem3[j][addr3[2*j+1]];
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pnz_blend.sv =====
`default_nettype none
module pnz_blend #(
    parameter int FRAC_BITS = pnz_pkg::PNZ_FRAC_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 en,
    input  wire logic [7:0][pnz_pkg::PNZ_ENTRY_W-1:0] hash_in,
    input  wire logic [FRAC_BITS-1:0]                 frac_x,
    input  wire logic [FRAC_BITS-1:0]                 frac_y,
    input  wire logic [FRAC_BITS-1:0]                 frac_z,
    input  wire logic [FRAC_BITS:0]                   fade_u,
    input  wire logic [FRAC_BITS:0]                   fade_v,
    input  wire logic [FRAC_BITS:0]                   fade_w,
    output logic      [pnz_pkg::PNZ_OUT_W-1:0]        noise_out
);
    import pnz_pkg::*;

    // gradient sums reach +2.0 exactly, one bit above signed q2
    localparam int F    = FRAC_BITS;
    localparam int GW   = F + 3;
    localparam int DW   = F + 4;
    localparam int PW   = 2 * F + 6;
    localparam int XW   = F + 18;
    localparam int SH_R = (F >= 16) ? F - 16 : 0;
    localparam int SH_L = (F < 16) ? 16 - F : 0;

    function automatic logic signed [GW-1:0] grad(
        input logic [3:0]           h,
        input logic signed [GW-1:0] x,
        input logic signed [GW-1:0] y,
        input logic signed [GW-1:0] z
    );
        logic signed [GW-1:0] a;
        logic signed [GW-1:0] b;
        a = (h < 4'd8) ? x : y;
        b = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        if (h[0]) a = -a;
        if (h[1]) b = -b;
        return a + b;
    endfunction

    logic signed [GW-1:0] cx [2];
    logic signed [GW-1:0] cy [2];
    logic signed [GW-1:0] cz [2];

    logic signed [GW-1:0] g_reg [8];
    logic [F:0]           u5_reg, v5_reg, w5_reg;
    logic signed [DW-1:0] d5 [4];
    logic signed [GW-1:0] lo6_reg [4];
    logic signed [PW-1:0] p6_reg [4];
    logic [F:0]           v6_reg, w6_reg;
    logic signed [GW-1:0] x7_reg [4];
    logic [F:0]           v7_reg, w7_reg;
    logic signed [DW-1:0] d7 [2];
    logic signed [GW-1:0] lo8_reg [2];
    logic signed [PW-1:0] p8_reg [2];
    logic [F:0]           w8_reg;
    logic signed [GW-1:0] y9_reg [2];
    logic [F:0]           w9_reg;
    logic signed [DW-1:0] d9;
    logic signed [GW-1:0] lo10_reg;
    logic signed [PW-1:0] p10_reg;
    logic signed [PW-1:0] r_full;
    logic signed [GW-1:0] r;
    logic [F:0]           rc;
    logic [XW-1:0]        rx;

    always_comb begin
        cx[0] = $signed(GW'(frac_x));
        cy[0] = $signed(GW'(frac_y));
        cz[0] = $signed(GW'(frac_z));
        cx[1] = cx[0] - $signed(GW'(1) << F);
        cy[1] = cy[0] - $signed(GW'(1) << F);
        cz[1] = cz[0] - $signed(GW'(1) << F);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 8; k++) begin
                g_reg[k] <= grad(hash_in[k][3:0], cx[k % 2], cy[(k / 2) % 2], cz[k / 4]);
            end
            u5_reg <= fade_u;
            v5_reg <= fade_v;
            w5_reg <= fade_w;
        end
    end

    // x lerps, pair p = y + 2z
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            d5[p] = DW'(g_reg[2*p+1]) - DW'(g_reg[2*p]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p < 4; p++) begin
                lo6_reg[p] <= g_reg[2*p];
                p6_reg[p]  <= $signed({1'b0, u5_reg}) * d5[p];
            end
            v6_reg <= v5_reg;
            w6_reg <= w5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p < 4; p++) begin
                x7_reg[p] <= lo6_reg[p] + GW'(p6_reg[p] >>> F);
            end
            v7_reg <= v6_reg;
            w7_reg <= w6_reg;
        end
    end

    // y lerps
    always_comb begin
        for (int q = 0; q < 2; q++) begin
            d7[q] = DW'(x7_reg[2*q+1]) - DW'(x7_reg[2*q]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int q = 0; q < 2; q++) begin
                lo8_reg[q] <= x7_reg[2*q];
                p8_reg[q]  <= $signed({1'b0, v7_reg}) * d7[q];
            end
            w8_reg <= w7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int q = 0; q < 2; q++) begin
                y9_reg[q] <= lo8_reg[q] + GW'(p8_reg[q] >>> F);
            end
            w9_reg <= w8_reg;
        end
    end

    // z lerp
    assign d9 = DW'(y9_reg[1]) - DW'(y9_reg[0]);

    always_ff @(posedge aclk) begin
        if (en) begin
            lo10_reg <= y9_reg[0];
            p10_reg  <= $signed({1'b0, w9_reg}) * d9;
        end
    end

    assign r_full = p10_reg >>> F;
    assign r      = lo10_reg + GW'(r_full);

    always_comb begin
        if (r < 0) begin
            rc = '0;
        end else if (r > $signed(GW'(1) << F)) begin
            rc = (F+1)'(1) << F;
        end else begin
            rc = r[F:0];
        end
        rx        = (XW'(rc) >> SH_R) << SH_L;
        noise_out = rx[PNZ_OUT_W-1:0];
    end

endmodule
`default_nettype wire
